FILE: hw/rtl/ace_pkg.sv
// ace_pkg: shared types, codes and helpers of the arp cache engine
// used by ace_lru, ace_core and arp_cache_engine_unit; no dependencies
package ace_pkg;

    localparam int IDX_MAX_W   = 6;   // slot index width at the largest cache size
    localparam int CNT_MAX_W   = 7;
    localparam int SLOT_W      = 4;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = 5;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    // op codes of an input beat
    localparam logic [1:0] OP_LEARN   = 2'd0;
    localparam logic [1:0] OP_RESOLVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // result kinds
    localparam logic [3:0] KIND_LEARNED  = 4'd0;
    localparam logic [3:0] KIND_NO_ROOM  = 4'd1;
    localparam logic [3:0] KIND_REPLY    = 4'd2;
    localparam logic [3:0] KIND_RELEASE  = 4'd3;
    localparam logic [3:0] KIND_TRANSMIT = 4'd4;
    localparam logic [3:0] KIND_QUEUED   = 4'd5;
    localparam logic [3:0] KIND_Q_FULL   = 4'd6;
    localparam logic [3:0] KIND_NEW_REQ  = 4'd7;
    localparam logic [3:0] KIND_HIT      = 4'd8;
    localparam logic [3:0] KIND_BCAST    = 4'd9;
    localparam logic [3:0] KIND_MISS     = 4'd10;
    localparam logic [3:0] KIND_REREQ    = 4'd11;
    localparam logic [3:0] KIND_FREED    = 4'd12;
    localparam logic [3:0] KIND_EVICTED  = 4'd13;

    // register indexes of the config port
    localparam logic [2:0] REG_OWN_ADDRESS   = 3'd0;
    localparam logic [2:0] REG_SUBNET_MASK   = 3'd1;
    localparam logic [2:0] REG_STABLE_TICKS  = 3'd2;
    localparam logic [2:0] REG_PENDING_TICKS = 3'd3;
    localparam logic [2:0] REG_RETRY_LIMIT   = 3'd4;
    localparam logic [2:0] REG_QUEUE_LIMIT   = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] proto_addr;
        logic [47:0] hw_addr;
        logic [31:0] target_addr;
        logic        is_request;
    } ace_in_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] out_proto;
        logic [47:0] out_hw;
        logic [3:0]  slot;
        logic [5:0]  pkt_count;
        logic        last;
    } ace_out_t;

    typedef struct packed {
        logic [31:0] own_address;
        logic [31:0] subnet_mask;
        logic [15:0] stable_ticks;
        logic [15:0] pending_ticks;
        logic [7:0]  retry_limit;
        logic [5:0]  queue_limit;
    } ace_cfg_t;

    typedef struct packed {
        logic        resolved;
        logic [31:0] proto;
        logic [47:0] hw;
        logic [15:0] timeout;
        logic [7:0]  retries;
        logic [5:0]  queued;
    } ace_entry_t;

    typedef enum logic [1:0] {
        LRU_NONE,
        LRU_TOUCH,
        LRU_INSERT,
        LRU_REMOVE
    } ace_lru_op_t;

    typedef struct packed {
        ace_lru_op_t          op;
        logic [IDX_MAX_W-1:0] slot;
        logic [IDX_MAX_W-1:0] qrank;
        logic [IDX_MAX_W-1:0] qslot;
    } ace_lru_cmd_t;

    typedef struct packed {
        logic                 free_found;
        logic [IDX_MAX_W-1:0] free_slot;
        logic                 rank_found;
        logic [IDX_MAX_W-1:0] rank_slot;
        logic                 slot_valid;
        logic [CNT_MAX_W-1:0] count;
    } ace_lru_stat_t;

    function automatic logic is_bcast(input logic [31:0] a, input logic [31:0] mask);
        logic [31:0] host;
        host = ~mask;
        return (a == 32'hFFFF_FFFF) || ((a & host) == host);
    endfunction

    function automatic ace_out_t make_res(input logic [3:0] kind, input logic [31:0] proto,
                                          input logic [47:0] hw, input logic [3:0] slot,
                                          input logic [5:0] cnt);
        ace_out_t r;
        r.kind      = kind;
        r.out_proto = proto;
        r.out_hw    = hw;
        r.slot      = slot;
        r.pkt_count = cnt;
        r.last      = 1'b0;
        return r;
    endfunction

endpackage

FILE: hw/rtl/arp_cache_engine_unit.sv
// arp_cache_engine_unit: top level with the config registers of the arp cache engine
// depends on ace_pkg, ace_lru and ace_core
//
// An IPv4-to-MAC cache of ENTRIES slots in least-recently-used order. One request beat
// is taken at a time; req_ready stays low until its last result beat has been staged.
// A learn, resolve or lookup walks the address tags one slot per cycle and stops at the
// matching slot; a resolve or lookup of a broadcast address skips the walk. A tick
// selects each valid slot in rank order and then updates it. This pace is set by the
// single-port entry store, which the sequencer reads and writes one slot per cycle.
// Results come out one beat per cycle at most, through a one-deep output register,
// and a stalled rsp_ready holds the sequencer. No clearing pass runs after reset.
module arp_cache_engine_unit import ace_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  ace_in_t               req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output ace_out_t              rsp_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    ace_cfg_t      cfg_reg;
    ace_lru_cmd_t  lru_cmd;
    ace_lru_stat_t lru_stat;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address   <= 32'h0000_0000;
            cfg_reg.subnet_mask   <= 32'hFFFF_FF00;
            cfg_reg.stable_ticks  <= 16'd20;
            cfg_reg.pending_ticks <= 16'd3;
            cfg_reg.retry_limit   <= 8'd5;
            cfg_reg.queue_limit   <= 6'd4;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_OWN_ADDRESS:   cfg_reg.own_address   <= pwdata;
                REG_SUBNET_MASK:   cfg_reg.subnet_mask   <= pwdata;
                REG_STABLE_TICKS:  cfg_reg.stable_ticks  <= pwdata[15:0];
                REG_PENDING_TICKS: cfg_reg.pending_ticks <= pwdata[15:0];
                REG_RETRY_LIMIT:   cfg_reg.retry_limit   <= pwdata[7:0];
                REG_QUEUE_LIMIT:   cfg_reg.queue_limit   <= pwdata[5:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_OWN_ADDRESS:   prdata = cfg_reg.own_address;
            REG_SUBNET_MASK:   prdata = cfg_reg.subnet_mask;
            REG_STABLE_TICKS:  prdata = APB_DATA_W'(cfg_reg.stable_ticks);
            REG_PENDING_TICKS: prdata = APB_DATA_W'(cfg_reg.pending_ticks);
            REG_RETRY_LIMIT:   prdata = APB_DATA_W'(cfg_reg.retry_limit);
            REG_QUEUE_LIMIT:   prdata = APB_DATA_W'(cfg_reg.queue_limit);
            default:           prdata = '0;
        endcase
    end

    ace_lru #(
        .ENTRIES (ENTRIES)
    ) u_lru (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (lru_cmd),
        .stat  (lru_stat)
    );

    ace_core #(
        .ENTRIES (ENTRIES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .lru_cmd   (lru_cmd),
        .lru_stat  (lru_stat)
    );

endmodule

FILE: hw/rtl/ace_lru.sv
// ace_lru: valid bits, recency ranks and fill count of the cache slots
// depends on ace_pkg for the command and status structs
module ace_lru import ace_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ace_lru_cmd_t  cmd,
    output ace_lru_stat_t stat
);

    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [SW-1:0]      rank_reg  [ENTRIES];
    logic [SW-1:0]      rank_next [ENTRIES];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [SW-1:0]      sel;
    logic [SW-1:0]      sel_rank;
    logic [SW-1:0]      qrank;

    assign sel      = cmd.slot[SW-1:0];
    assign sel_rank = rank_reg[sel];
    assign qrank    = cmd.qrank[SW-1:0];

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        unique case (cmd.op)
            LRU_TOUCH:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (SW'(i) != sel && valid_reg[i] && rank_reg[i] < sel_rank)
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                rank_next[sel] = '0;
            end
            LRU_INSERT:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (SW'(i) != sel && valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                rank_next[sel]  = '0;
                valid_next[sel] = 1'b1;
                count_next      = count_reg + 1'b1;
            end
            LRU_REMOVE:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (SW'(i) != sel && valid_reg[i] && rank_reg[i] > sel_rank)
                    begin
                        rank_next[i] = rank_reg[i] - 1'b1;
                    end
                end
                valid_next[sel] = 1'b0;
                count_next      = count_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // lowest free slot and the slot holding the queried rank
    always_comb
    begin
        stat.free_found = 1'b0;
        stat.free_slot  = '0;
        stat.rank_found = 1'b0;
        stat.rank_slot  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                stat.free_found = 1'b1;
                stat.free_slot  = IDX_MAX_W'(i);
            end
            if (valid_reg[i] && rank_reg[i] == qrank)
            begin
                stat.rank_found = 1'b1;
                stat.rank_slot  = IDX_MAX_W'(i);
            end
        end
        stat.slot_valid = valid_reg[cmd.qslot[SW-1:0]];
        stat.count      = CNT_MAX_W'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_reg[i] <= rank_next[i];
        end
    end

endmodule

FILE: hw/rtl/ace_core.sv
// ace_core: entry store, sequencer and result staging of the arp cache engine
// depends on ace_pkg; drives ace_lru through a command struct
module ace_core import ace_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ace_cfg_t      cfg,
    input  logic          req_valid,
    output logic          req_ready,
    input  ace_in_t       req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ace_out_t      rsp_data,
    output ace_lru_cmd_t  lru_cmd,
    input  ace_lru_stat_t lru_stat
);

    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_HIT,
        ST_MISS,
        ST_EVICT,
        ST_NEW,
        ST_L_REL,
        ST_L_REPLY,
        ST_BCAST,
        ST_TICK_SEL,
        ST_TICK_UPD,
        ST_DONE
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    ace_in_t              item_reg;
    logic [SW-1:0]        ptr_reg;
    logic [SW-1:0]        ptr_next;
    logic [CW-1:0]        r_reg;
    logic [CW-1:0]        r_next;
    logic [5:0]           q_reg;
    logic [5:0]           q_next;
    logic [SW-1:0]        rep_reg;
    logic [SW-1:0]        rep_next;
    logic [RES_CNT_W-1:0] nres_reg;
    ace_out_t             hold_reg;
    logic                 hold_valid_reg;
    ace_out_t             out_reg;
    logic                 out_valid_reg;

    ace_entry_t           mem [ENTRIES];
    ace_entry_t           rd_data_reg;
    ace_entry_t           wr_data;
    logic                 wr_en;

    logic                 emit_ok;
    logic                 emit_req;
    ace_out_t             emit_res;
    logic                 flush;
    logic                 for_me;
    logic [5:0]           q_inc;
    ace_entry_t           d;

    assign d         = rd_data_reg;
    assign for_me    = (item_reg.target_addr == cfg.own_address);
    assign emit_ok   = !hold_valid_reg || !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;
    assign q_inc     = (d.queued == 6'h3F) ? d.queued : d.queued + 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        rep_next      = rep_reg;
        emit_req      = 1'b0;
        emit_res      = '0;
        flush         = 1'b0;
        wr_en         = 1'b0;
        wr_data       = d;
        lru_cmd.op    = LRU_NONE;
        lru_cmd.slot  = IDX_MAX_W'(ptr_reg);
        lru_cmd.qslot = IDX_MAX_W'(ptr_reg);
        lru_cmd.qrank = (state_reg == ST_MISS) ? IDX_MAX_W'(ENTRIES - 1) : IDX_MAX_W'(r_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ptr_next = '0;
                    r_next   = '0;
                    unique case (req_data.op)
                        OP_LEARN:   state_next = ST_FIND;
                        OP_TICK:    state_next = ST_TICK_SEL;
                        default:
                        begin
                            state_next = is_bcast(req_data.proto_addr, cfg.subnet_mask)
                                         ? ST_BCAST : ST_FIND;
                        end
                    endcase
                end
            end
            ST_FIND:
            begin
                // one tag per cycle in slot order
                if (lru_stat.slot_valid && d.proto == item_reg.proto_addr)
                begin
                    state_next = ST_HIT;
                end
                else if (ptr_reg == SW'(ENTRIES - 1))
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_HIT:
            begin
                if (emit_ok)
                begin
                    lru_cmd.op = LRU_TOUCH;
                    emit_req   = 1'b1;
                    state_next = ST_DONE;
                    unique case (item_reg.op)
                        OP_LEARN:
                        begin
                            wr_en            = 1'b1;
                            wr_data.resolved = 1'b1;
                            wr_data.proto    = item_reg.proto_addr;
                            wr_data.hw       = item_reg.hw_addr;
                            wr_data.timeout  = cfg.stable_ticks;
                            wr_data.retries  = cfg.retry_limit;
                            wr_data.queued   = '0;
                            q_next           = d.queued;
                            rep_next         = ptr_reg;
                            emit_res   = make_res(KIND_LEARNED, item_reg.proto_addr,
                                                  item_reg.hw_addr, SLOT_W'(ptr_reg), '0);
                            state_next = ST_L_REL;
                        end
                        OP_LOOKUP:
                        begin
                            if (d.resolved)
                            begin
                                emit_res = make_res(KIND_HIT, item_reg.proto_addr, d.hw,
                                                    SLOT_W'(ptr_reg), '0);
                            end
                            else
                            begin
                                emit_res = make_res(KIND_MISS, item_reg.proto_addr, '0,
                                                    SLOT_W'(ptr_reg), '0);
                            end
                        end
                        default:
                        begin
                            if (d.resolved)
                            begin
                                emit_res = make_res(KIND_TRANSMIT, item_reg.proto_addr, d.hw,
                                                    SLOT_W'(ptr_reg), '0);
                            end
                            else if (d.queued <= cfg.queue_limit)
                            begin
                                wr_en          = 1'b1;
                                wr_data.queued = q_inc;
                                emit_res = make_res(KIND_QUEUED, item_reg.proto_addr, '0,
                                                    SLOT_W'(ptr_reg), q_inc);
                            end
                            else
                            begin
                                emit_res = make_res(KIND_Q_FULL, item_reg.proto_addr, '0,
                                                    SLOT_W'(ptr_reg), 6'd1);
                            end
                        end
                    endcase
                end
            end
            ST_MISS:
            begin
                if (emit_ok)
                begin
                    if (item_reg.op == OP_LOOKUP)
                    begin
                        emit_req   = 1'b1;
                        emit_res   = make_res(KIND_MISS, item_reg.proto_addr, '0, '0, '0);
                        state_next = ST_DONE;
                    end
                    else if (lru_stat.free_found)
                    begin
                        ptr_next   = lru_stat.free_slot[SW-1:0];
                        state_next = ST_NEW;
                    end
                    else if (item_reg.op == OP_RESOLVE || for_me)
                    begin
                        // full: the least recent slot goes
                        ptr_next   = lru_stat.rank_slot[SW-1:0];
                        state_next = ST_EVICT;
                    end
                    else
                    begin
                        emit_req   = 1'b1;
                        emit_res   = make_res(KIND_NO_ROOM, item_reg.proto_addr, '0, '0, '0);
                        rep_next   = '0;
                        state_next = ST_L_REPLY;
                    end
                end
            end
            ST_EVICT:
            begin
                if (emit_ok)
                begin
                    lru_cmd.op = LRU_REMOVE;
                    emit_req   = 1'b1;
                    emit_res   = make_res(KIND_EVICTED, d.proto, d.hw, SLOT_W'(ptr_reg),
                                          d.queued);
                    state_next = ST_NEW;
                end
            end
            ST_NEW:
            begin
                if (emit_ok)
                begin
                    lru_cmd.op      = LRU_INSERT;
                    wr_en           = 1'b1;
                    emit_req        = 1'b1;
                    rep_next        = ptr_reg;
                    wr_data.proto   = item_reg.proto_addr;
                    wr_data.retries = cfg.retry_limit;
                    if (item_reg.op == OP_LEARN)
                    begin
                        wr_data.resolved = 1'b1;
                        wr_data.hw       = item_reg.hw_addr;
                        wr_data.timeout  = cfg.stable_ticks;
                        wr_data.queued   = '0;
                        emit_res   = make_res(KIND_LEARNED, item_reg.proto_addr,
                                              item_reg.hw_addr, SLOT_W'(ptr_reg), '0);
                        state_next = ST_L_REPLY;
                    end
                    else
                    begin
                        wr_data.resolved = 1'b0;
                        wr_data.hw       = '0;
                        wr_data.timeout  = cfg.pending_ticks;
                        wr_data.queued   = 6'd1;
                        emit_res   = make_res(KIND_NEW_REQ, item_reg.proto_addr, '0,
                                              SLOT_W'(ptr_reg), 6'd1);
                        state_next = ST_DONE;
                    end
                end
            end
            ST_L_REL:
            begin
                if (q_reg == '0)
                begin
                    state_next = ST_L_REPLY;
                end
                else if (emit_ok)
                begin
                    emit_req   = 1'b1;
                    emit_res   = make_res(KIND_RELEASE, item_reg.proto_addr, item_reg.hw_addr,
                                          SLOT_W'(ptr_reg), q_reg);
                    state_next = ST_L_REPLY;
                end
            end
            ST_L_REPLY:
            begin
                if (!(for_me && item_reg.is_request))
                begin
                    state_next = ST_DONE;
                end
                else if (emit_ok)
                begin
                    emit_req   = 1'b1;
                    emit_res   = make_res(KIND_REPLY, item_reg.proto_addr, item_reg.hw_addr,
                                          SLOT_W'(rep_reg), '0);
                    state_next = ST_DONE;
                end
            end
            ST_BCAST:
            begin
                if (emit_ok)
                begin
                    emit_req   = 1'b1;
                    emit_res   = make_res(KIND_BCAST, item_reg.proto_addr, '1, '0, '0);
                    state_next = ST_DONE;
                end
            end
            ST_TICK_SEL:
            begin
                if (r_reg < lru_stat.count[CW-1:0])
                begin
                    ptr_next   = lru_stat.rank_slot[SW-1:0];
                    state_next = ST_TICK_UPD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_TICK_UPD:
            begin
                if (d.timeout > 16'd1)
                begin
                    wr_en           = 1'b1;
                    wr_data.timeout = d.timeout - 1'b1;
                    r_next          = r_reg + 1'b1;
                    state_next      = ST_TICK_SEL;
                end
                else if (emit_ok)
                begin
                    wr_en      = 1'b1;
                    emit_req   = 1'b1;
                    state_next = ST_TICK_SEL;
                    if (d.resolved)
                    begin
                        wr_data.resolved = 1'b0;
                        wr_data.timeout  = cfg.pending_ticks;
                        wr_data.retries  = cfg.retry_limit;
                        emit_res = make_res(KIND_REREQ, d.proto, '0, SLOT_W'(ptr_reg), '0);
                        r_next   = r_reg + 1'b1;
                    end
                    else if (d.retries <= 8'd1)
                    begin
                        // later ranks slide down, so the walk stays at this rank
                        wr_data.retries = '0;
                        wr_data.queued  = '0;
                        lru_cmd.op      = LRU_REMOVE;
                        emit_res = make_res(KIND_FREED, d.proto, '0, SLOT_W'(ptr_reg),
                                            d.queued);
                    end
                    else
                    begin
                        wr_data.retries = d.retries - 1'b1;
                        wr_data.timeout = cfg.pending_ticks;
                        emit_res = make_res(KIND_REREQ, d.proto, '0, SLOT_W'(ptr_reg), '0);
                        r_next   = r_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    flush      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // entry store, read data always reflects the slot under ptr_reg
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ptr_reg] <= wr_data;
        end
        if (wr_en && ptr_reg == ptr_next)
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            item_reg       <= '0;
            ptr_reg        <= '0;
            r_reg          <= '0;
            q_reg          <= '0;
            rep_reg        <= '0;
            nres_reg       <= '0;
            hold_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            r_reg     <= r_next;
            q_reg     <= q_next;
            rep_reg   <= rep_next;
            if (state_reg == ST_IDLE && req_valid)
            begin
                item_reg <= req_data;
                nres_reg <= '0;
            end
            if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // newest result waits in hold until the next one shows it was not the last
            if (emit_req && nres_reg < RES_CNT_W'(MAX_RESULTS))
            begin
                hold_reg       <= emit_res;
                hold_valid_reg <= 1'b1;
                nres_reg       <= nres_reg + 1'b1;
                if (hold_valid_reg)
                begin
                    out_reg       <= hold_reg;
                    out_valid_reg <= 1'b1;
                end
            end
            if (flush)
            begin
                if (hold_valid_reg)
                begin
                    out_reg      <= hold_reg;
                    out_reg.last <= 1'b1;
                end
                else
                begin
                    out_reg      <= make_res(KIND_EVICTED, '0, '0, '0, '0);
                    out_reg.last <= 1'b1;
                end
                hold_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
        end
    end

endmodule

FILE: test/arp_cache_engine_unit_tb.sv
// arp_cache_engine_unit_tb: self-checking bench for the arp cache engine
// drives request beats and apb register writes, predicts every result beat in
// a local cache model and compares field by field; depends on ace_pkg and the dut
`timescale 1ns / 1ps

module arp_cache_engine_unit_tb;
    import ace_pkg::*;

    localparam int N_SLOTS     = 16;
    localparam int CYCLE_LIMIT = 1500000;
    localparam logic [47:0] MAC_ALL = 48'hFFFF_FFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    ace_in_t               req_data;
    logic                  rsp_valid;
    logic                  rsp_ready;
    ace_out_t              rsp_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    arp_cache_engine_unit #(.ENTRIES(N_SLOTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow registers
    logic [31:0] m_own, m_mask;
    logic [15:0] m_stable, m_pending;
    logic [7:0]  m_retry;
    logic [5:0]  m_qlim;

    // shadow cache
    logic        c_valid [N_SLOTS];
    logic        c_res   [N_SLOTS];
    logic [31:0] c_proto [N_SLOTS];
    logic [47:0] c_hw    [N_SLOTS];
    logic [15:0] c_tmo   [N_SLOTS];
    logic [7:0]  c_retr  [N_SLOTS];
    logic [5:0]  c_queued[N_SLOTS];
    int          c_rank  [N_SLOTS];

    ace_out_t pending_rsp[$];
    ace_out_t item_rsp[$];
    int  mismatches = 0;
    int  dir_errors;
    int  cycles = 0;
    int  send_idle_pct, recv_idle_pct;
    bit  hold_rsp;
    bit  hold_go;
    logic [31:0] known_addr[$];

    // ---------------- cache model ----------------
    function automatic void push_rsp(logic [3:0] k, logic [31:0] p, logic [47:0] h,
                                     int s, logic [5:0] c);
        ace_out_t r;
        if (item_rsp.size() >= MAX_RESULTS)
            return;
        r.kind = k; r.out_proto = p; r.out_hw = h; r.slot = s[3:0];
        r.pkt_count = c; r.last = 1'b0;
        item_rsp.push_back(r);
    endfunction

    function automatic void touch_slot(int s);
        for (int i = 0; i < N_SLOTS; i++)
            if (i != s && c_valid[i] && c_rank[i] < c_rank[s]) c_rank[i]++;
        c_rank[s] = 0;
    endfunction

    function automatic void push_front(int s);
        for (int i = 0; i < N_SLOTS; i++)
            if (i != s && c_valid[i]) c_rank[i]++;
        c_rank[s] = 0;
        c_valid[s] = 1'b1;
    endfunction

    function automatic void drop_slot(int s);
        for (int i = 0; i < N_SLOTS; i++)
            if (i != s && c_valid[i] && c_rank[i] > c_rank[s]) c_rank[i]--;
        c_valid[s] = 1'b0;
    endfunction

    function automatic int find_entry(logic [31:0] a);
        for (int i = 0; i < N_SLOTS; i++)
            if (c_valid[i] && c_proto[i] == a)
            begin
                touch_slot(i);
                return i;
            end
        return -1;
    endfunction

    function automatic int grab_slot(bit evict);
        int tail;
        tail = -1;
        for (int i = 0; i < N_SLOTS; i++)
            if (!c_valid[i]) return i;
        if (!evict) return -1;
        for (int i = 0; i < N_SLOTS; i++)
            if (tail < 0 || c_rank[i] > c_rank[tail]) tail = i;
        push_rsp(KIND_EVICTED, c_proto[tail], c_hw[tail], tail, c_queued[tail]);
        drop_slot(tail);
        return tail;
    endfunction

    function automatic void fill_entry(int s, logic [31:0] p, logic [47:0] h, bit res);
        c_proto[s] = p;
        c_hw[s]    = h;
        c_res[s]   = res;
        c_tmo[s]   = res ? m_stable : m_pending;
        c_retr[s]  = m_retry;
    endfunction

    function automatic void predict_item(ace_in_t it);
        int s;
        int order[$];
        bit for_us;
        item_rsp.delete();
        case (it.op)
            OP_LEARN:
            begin
                for_us = (it.target_addr == m_own);
                s = find_entry(it.proto_addr);
                if (s >= 0)
                begin
                    fill_entry(s, it.proto_addr, it.hw_addr, 1'b1);
                    push_rsp(KIND_LEARNED, it.proto_addr, it.hw_addr, s, 0);
                    if (c_queued[s] != 0)
                    begin
                        push_rsp(KIND_RELEASE, it.proto_addr, it.hw_addr, s, c_queued[s]);
                        c_queued[s] = 0;
                    end
                end
                else
                begin
                    s = grab_slot(for_us);
                    if (s < 0)
                        push_rsp(KIND_NO_ROOM, it.proto_addr, 48'd0, 0, 0);
                    else
                    begin
                        fill_entry(s, it.proto_addr, it.hw_addr, 1'b1);
                        c_queued[s] = 0;
                        push_front(s);
                        push_rsp(KIND_LEARNED, it.proto_addr, it.hw_addr, s, 0);
                    end
                end
                if (for_us && it.is_request)
                    push_rsp(KIND_REPLY, it.proto_addr, it.hw_addr, s >= 0 ? s : 0, 0);
            end
            OP_RESOLVE, OP_LOOKUP:
            begin
                if (it.proto_addr == 32'hFFFF_FFFF
                    || (it.proto_addr & ~m_mask) == ~m_mask)
                    push_rsp(KIND_BCAST, it.proto_addr, MAC_ALL, 0, 0);
                else
                begin
                    s = find_entry(it.proto_addr);
                    if (it.op == OP_LOOKUP)
                    begin
                        if (s >= 0 && c_res[s])
                            push_rsp(KIND_HIT, it.proto_addr, c_hw[s], s, 0);
                        else
                            push_rsp(KIND_MISS, it.proto_addr, 48'd0, s >= 0 ? s : 0, 0);
                    end
                    else if (s >= 0)
                    begin
                        if (c_res[s])
                            push_rsp(KIND_TRANSMIT, it.proto_addr, c_hw[s], s, 0);
                        else if (c_queued[s] <= m_qlim)
                        begin
                            if (c_queued[s] < 63) c_queued[s]++;
                            push_rsp(KIND_QUEUED, it.proto_addr, 48'd0, s, c_queued[s]);
                        end
                        else
                            push_rsp(KIND_Q_FULL, it.proto_addr, 48'd0, s, 1);
                    end
                    else
                    begin
                        s = grab_slot(1'b1);
                        fill_entry(s, it.proto_addr, 48'd0, 1'b0);
                        c_queued[s] = 1;
                        push_front(s);
                        push_rsp(KIND_NEW_REQ, it.proto_addr, 48'd0, s, 1);
                    end
                end
            end
            default:
            begin
                // age in lru order, most recent first
                for (int r = 0; r < N_SLOTS; r++)
                    for (int i = 0; i < N_SLOTS; i++)
                        if (c_valid[i] && c_rank[i] == r) order.push_back(i);
                foreach (order[k])
                begin
                    s = order[k];
                    if (c_tmo[s] > 1)
                        c_tmo[s]--;
                    else if (c_res[s])
                    begin
                        c_res[s]  = 1'b0;
                        c_tmo[s]  = m_pending;
                        c_retr[s] = m_retry;
                        push_rsp(KIND_REREQ, c_proto[s], 48'd0, s, 0);
                    end
                    else if (c_retr[s] <= 1)
                    begin
                        c_retr[s] = 0;
                        push_rsp(KIND_FREED, c_proto[s], 48'd0, s, c_queued[s]);
                        c_queued[s] = 0;
                        drop_slot(s);
                    end
                    else
                    begin
                        c_retr[s]--;
                        c_tmo[s] = m_pending;
                        push_rsp(KIND_REREQ, c_proto[s], 48'd0, s, 0);
                    end
                end
                if (item_rsp.size() == 0)
                    push_rsp(KIND_EVICTED, 32'd0, 48'd0, 0, 0);
            end
        endcase
        item_rsp[item_rsp.size() - 1].last = 1'b1;
        foreach (item_rsp[k]) pending_rsp.push_back(item_rsp[k]);
    endfunction

    // ---------------- clock, reset, limit ----------------
    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- result checking ----------------
    always @(posedge clk)
    begin
        ace_out_t exp_r;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat kind=%0d proto=%h", rsp_data.kind,
                             rsp_data.out_proto);
            end
            else
            begin
                exp_r = pending_rsp.pop_front();
                if (rsp_data.kind !== exp_r.kind || rsp_data.out_proto !== exp_r.out_proto
                    || rsp_data.out_hw !== exp_r.out_hw || rsp_data.slot !== exp_r.slot
                    || rsp_data.pkt_count !== exp_r.pkt_count
                    || rsp_data.last !== exp_r.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp k=%0d p=%h hw=%h s=%0d c=%0d l=%0b",
                                 exp_r.kind, exp_r.out_proto, exp_r.out_hw, exp_r.slot,
                                 exp_r.pkt_count, exp_r.last,
                                 " got k=%0d p=%h hw=%h s=%0d c=%0d l=%0b",
                                 rsp_data.kind, rsp_data.out_proto, rsp_data.out_hw,
                                 rsp_data.slot, rsp_data.pkt_count, rsp_data.last);
                end
            end
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_rsp)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------- driving ----------------
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, 2'b00}); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_OWN_ADDRESS:   m_own     = val;
            REG_SUBNET_MASK:   m_mask    = val;
            REG_STABLE_TICKS:  m_stable  = val[15:0];
            REG_PENDING_TICKS: m_pending = val[15:0];
            REG_RETRY_LIMIT:   m_retry   = val[7:0];
            default:           m_qlim    = val[5:0];
        endcase
    endtask

    // valid stays up between back to back beats, drops only for an idle gap
    task automatic send_item(ace_in_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_item(it);
    endtask

    // wait until idle so registers may be written
    task automatic drain_results();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * N_SLOTS + 10) @(posedge clk);
    endtask

    function automatic ace_in_t mk(logic [1:0] op, logic [31:0] a, logic [47:0] h,
                                   logic [31:0] t, logic rq);
        ace_in_t it;
        it.op = op; it.proto_addr = a; it.hw_addr = h; it.target_addr = t;
        it.is_request = rq;
        return it;
    endfunction

    function automatic logic [31:0] pick_addr();
        if (known_addr.size() != 0 && $urandom_range(99) < 70)
            return known_addr[$urandom_range(known_addr.size() - 1)];
        return {8'($urandom_range(255)), 8'd10, 8'd0, 8'($urandom_range(63))};
    endfunction

    function automatic ace_in_t rand_item();
        ace_in_t it;
        int pick;
        pick = $urandom_range(99);
        it.hw_addr     = 48'({$urandom(), $urandom()});
        it.is_request  = 1'($urandom_range(1));
        it.proto_addr  = pick_addr();
        it.target_addr = ($urandom_range(99) < 50) ? m_own : $urandom();
        if (pick < 30) it.op = OP_LEARN;
        else if (pick < 60) it.op = OP_RESOLVE;
        else if (pick < 75) it.op = OP_LOOKUP;
        else it.op = OP_TICK;
        if ($urandom_range(99) < 4) it.proto_addr = $urandom();
        if ($urandom_range(99) < 3) it.proto_addr = 32'hFFFF_FFFF;
        if (known_addr.size() < 40) known_addr.push_back(it.proto_addr);
        return it;
    endfunction

    // directed rows: expected first result typed where obvious, else model only
    typedef struct {
        ace_in_t  it;
        bit       typed;
        ace_out_t exp_first;
    } dir_row_t;

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        ace_out_t none_r;
        ace_in_t  it;
        int n_items;

        dir_errors = 0; hold_go = 1'b0;
        send_idle_pct = 11; recv_idle_pct = 62;
        rst_n = 1'b0; req_valid = 1'b0; req_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        m_own = 0; m_mask = 32'hFFFF_FF00; m_stable = 20; m_pending = 3;
        m_retry = 5; m_qlim = 4;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            c_valid[i] = 0; c_res[i] = 0; c_proto[i] = 0; c_hw[i] = 0;
            c_tmo[i] = 0; c_retr[i] = 0; c_queued[i] = 0; c_rank[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part at reset settings ----
        none_r = '0; none_r.kind = KIND_EVICTED; none_r.last = 1'b1;
        row.typed = 1; row.it = mk(OP_TICK, 0, 0, 0, 0); row.exp_first = none_r;
        rows.push_back(row);
        row.it = mk(OP_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
        row.exp_first = '{KIND_BCAST, 32'hFFFF_FFFF, MAC_ALL, 4'd0, 6'd0, 1'b1};
        rows.push_back(row);
        row.it = mk(OP_RESOLVE, 32'h0A00_00FF, 0, 0, 0);
        row.exp_first = '{KIND_BCAST, 32'h0A00_00FF, MAC_ALL, 4'd0, 6'd0, 1'b1};
        rows.push_back(row);
        row.it = mk(OP_LOOKUP, 32'h0A00_0001, 0, 0, 0);
        row.exp_first = '{KIND_MISS, 32'h0A00_0001, 48'd0, 4'd0, 6'd0, 1'b1};
        rows.push_back(row);
        row.typed = 0;
        row.it = mk(OP_LEARN, 32'h0A00_0001, MAC_ALL, 32'd0, 1); rows.push_back(row);
        row.it = mk(OP_LOOKUP, 32'h0A00_0001, 0, 0, 0); rows.push_back(row);
        row.it = mk(OP_RESOLVE, 32'h0A00_0001, 0, 0, 0); rows.push_back(row);
        row.it = mk(OP_RESOLVE, 32'h0A00_0002, 0, 0, 0); rows.push_back(row);
        for (int k = 0; k < 6; k++)
        begin
            row.it = mk(OP_RESOLVE, 32'h0A00_0002, 0, 0, 0); rows.push_back(row);
        end
        row.it = mk(OP_LOOKUP, 32'h0A00_0002, 0, 0, 0); rows.push_back(row);
        row.it = mk(OP_LEARN, 32'h0A00_0002, 48'h0000_0000_0001, 32'hFFFF_FFFF, 1);
        rows.push_back(row);
        row.it = mk(OP_LEARN, 32'h0000_0000, 48'd0, 32'h0000_0001, 0); rows.push_back(row);
        for (int k = 0; k < 4; k++)
        begin
            row.it = mk(OP_TICK, 0, 0, 0, 0); rows.push_back(row);
        end
        foreach (rows[k])
        begin
            send_item(rows[k].it);
            if (rows[k].typed && item_rsp[0] != rows[k].exp_first)
            begin
                dir_errors++;
                $display("directed row %0d predicted kind %0d, expected %0d",
                         k, item_rsp[0].kind, rows[k].exp_first.kind);
            end
        end

        // fill the cache, then no-room and evicting learns and an evicting resolve
        drain_results();
        apb_write(REG_OWN_ADDRESS, 32'hC0A8_0001);
        apb_write(REG_STABLE_TICKS, 32'h0000_FFFF);
        for (int k = 0; k < N_SLOTS + 1; k++)
            send_item(mk(OP_LEARN, 32'h0A00_0100 + k, 48'({$urandom(), $urandom()}),
                         32'h0A00_0000, 0));
        send_item(mk(OP_LEARN, 32'h0A00_0200, 48'h1234, 32'hC0A8_0001, 1));
        send_item(mk(OP_RESOLVE, 32'h0A00_0300, 0, 0, 0));

        // ---- random phases over several settings ----
        n_items = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            drain_results();
            case (ph)
                0:
                begin
                    apb_write(REG_SUBNET_MASK, 32'hFFFF_FFFF);
                    apb_write(REG_STABLE_TICKS, 1);
                    apb_write(REG_PENDING_TICKS, 1);
                    apb_write(REG_RETRY_LIMIT, 1);
                    apb_write(REG_QUEUE_LIMIT, 0);
                end
                1:
                begin
                    apb_write(REG_SUBNET_MASK, 32'h0000_0000);
                    apb_write(REG_STABLE_TICKS, 32'h0000_FFFF);
                    apb_write(REG_PENDING_TICKS, 32'h0000_FFFF);
                    apb_write(REG_RETRY_LIMIT, 255);
                    apb_write(REG_QUEUE_LIMIT, 62);
                    apb_write(REG_OWN_ADDRESS, 32'hFFFF_FFFF);
                end
                2:
                begin
                    send_idle_pct = 62; recv_idle_pct = 11;
                    apb_write(REG_SUBNET_MASK, 32'hFFFF_FF00);
                    apb_write(REG_STABLE_TICKS, 6);
                    apb_write(REG_PENDING_TICKS, 2);
                    apb_write(REG_RETRY_LIMIT, 3);
                    apb_write(REG_QUEUE_LIMIT, 2);
                    apb_write(REG_OWN_ADDRESS, 32'h0A00_0005);
                end
                3:
                begin
                    apb_write(REG_STABLE_TICKS, 0);
                    apb_write(REG_PENDING_TICKS, 0);
                    apb_write(REG_RETRY_LIMIT, 0);
                end
                4:
                begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                    apb_write(REG_STABLE_TICKS, 4);
                    apb_write(REG_PENDING_TICKS, 2);
                    apb_write(REG_RETRY_LIMIT, 2);
                    apb_write(REG_QUEUE_LIMIT, 63);
                end
                default:
                begin
                    apb_write(REG_QUEUE_LIMIT, 3);
                    apb_write(REG_SUBNET_MASK, 32'hFFFF_FFF0);
                end
            endcase
            known_addr.delete();
            for (int k = 0; k < 72; k++)
            begin
                if (ph == 4 && k == 20) hold_go = 1'b1;
                it = rand_item();
                send_item(it);
                n_items++;
            end
        end
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4 * N_SLOTS + 20) @(posedge clk);
        if (mismatches == 0 && dir_errors == 0 && pending_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // long receiver hold-off so the output backs up into the request side
    initial
    begin
        int held;
        held = 0;
        hold_rsp = 1'b0;
        wait (hold_go);
        hold_rsp = 1'b1;
        while (held < 400)
        begin
            @(posedge clk);
            held++;
        end
        hold_rsp = 1'b0;
    end
endmodule
